// ===== src/rsad_pkg.sv =====
// ============================================================================
// rsad_pkg
// Shared types and constants for the RSA-from-primes decryption block.
// ============================================================================
package rsad_pkg;

   // Widest operand that the primality check accepts
   localparam int PRIME_BITS = 16;

   // Shared divider geometry
   localparam int DIV_DVD_W = 64;
   localparam int DIV_DSR_W = 32;
   localparam int DIV_LEN_W = 7;

   // Result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NOT_PRIME  = 2'd1;
   localparam logic [1:0] STATUS_NO_INVERSE = 2'd2;

   // Divider command: dividend is left-aligned, len bits are processed
   typedef struct packed {
      logic                 start;
      logic [DIV_LEN_W-1:0] len;
      logic [DIV_DVD_W-1:0] dividend;
      logic [DIV_DSR_W-1:0] divisor;
   } div_req_type;

   // Divider status: quotient sits in the low len bits of quotient
   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_DVD_W-1:0] quotient;
      logic [DIV_DSR_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== src/rsad_div.sv =====
// ============================================================================
// rsad_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ============================================================================
module rsad_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rsad_pkg::div_req_type div_req,
   output rsad_pkg::div_rsp_type div_rsp
);
   import rsad_pkg::*;

   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;
   logic [DIV_LEN_W-1:0] cnt_ff,   cnt_in;
   logic [DIV_DSR_W-1:0] rem_ff,   rem_in;
   logic [DIV_DVD_W-1:0] dvd_ff,   dvd_in;
   logic [DIV_DSR_W-1:0] dsr_ff,   dsr_in;

   logic [DIV_DSR_W:0]   rem_sh;
   logic [DIV_DSR_W:0]   rem_sub;
   logic                 ge;

   // One restoring step
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DIV_DVD_W-1]};
      ge      = (rem_sh >= {1'b0, dsr_ff});
      rem_sub = rem_sh - {1'b0, dsr_ff};
   end

   // Next state
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.len;
         rem_in  = '0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[DIV_DSR_W-1:0] : rem_sh[DIV_DSR_W-1:0];
         dvd_in = {dvd_ff[DIV_DVD_W-2:0], ge};
         cnt_in = cnt_ff - DIV_LEN_W'(1);
         if (cnt_ff == DIV_LEN_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = dvd_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== src/rsa_decrypt_from_primes.sv =====
// ============================================================================
// rsa_decrypt_from_primes
// Textbook RSA decryption from the primes of the modulus.
// ============================================================================
// Usage:
//   req_ channel carries one transaction per item: primes p and q, public
//   exponent e and a ciphertext. rsp_ channel returns one transaction per
//   item: plaintext, private exponent d and a status code.
//   One item is worked at a time; req_tready is high only while idle.
//   Every division-like step runs on one shared bit-serial divider, one bit
//   per cycle. Work per item:
//     trial division: up to sqrt(x) candidate divisors for each of p, q
//       and e;
//     inverse search: up to e tries;
//     modular power: up to 64 squarings or multiplies.
//   Results go to an output register; a stalled receiver lets the next item
//   be accepted and worked, and it waits at the end until the register frees.
//   Synchronous reset returns the block to idle with no result pending.
// ============================================================================
module rsa_decrypt_from_primes (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] prime_p, [31:16] prime_q, [47:32] pub_exponent, [79:48] cipher_value
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] plain_value, [63:32] priv_exponent, [65:64] status, rest zero
   output logic [71:0] rsp_tdata
);
   import rsad_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_PCHK    = 5'd1;
   localparam logic [4:0] S_PWAIT   = 5'd2;
   localparam logic [4:0] S_NMUL    = 5'd3;
   localparam logic [4:0] S_PHIMUL  = 5'd4;
   localparam logic [4:0] S_PHIDIV  = 5'd5;
   localparam logic [4:0] S_PHIWAIT = 5'd6;
   localparam logic [4:0] S_SRCH    = 5'd7;
   localparam logic [4:0] S_KMUL    = 5'd8;
   localparam logic [4:0] S_KDIV    = 5'd9;
   localparam logic [4:0] S_KWAIT   = 5'd10;
   localparam logic [4:0] S_CTDIV   = 5'd11;
   localparam logic [4:0] S_CTWAIT  = 5'd12;
   localparam logic [4:0] S_EXP     = 5'd13;
   localparam logic [4:0] S_RMUL    = 5'd14;
   localparam logic [4:0] S_RDIV    = 5'd15;
   localparam logic [4:0] S_RWAIT   = 5'd16;
   localparam logic [4:0] S_SMUL    = 5'd17;
   localparam logic [4:0] S_SDIV    = 5'd18;
   localparam logic [4:0] S_SWAIT   = 5'd19;
   localparam logic [4:0] S_DONE    = 5'd20;

   localparam logic [1:0] OP_P = 2'd0;
   localparam logic [1:0] OP_Q = 2'd1;
   localparam logic [1:0] OP_E = 2'd2;

   localparam logic [32:0] PRIME_LIM = (33'd1 << PRIME_BITS) - 33'd1;

   logic [4:0]  state_ff, state_in;
   logic [15:0] p_ff, p_in, q_ff, q_in, e_ff, e_in;
   logic [31:0] ct_ff, ct_in;
   logic [1:0]  op_ff, op_in;
   logic [8:0]  i_ff, i_in;
   logic [17:0] isq_ff, isq_in;
   logic [31:0] n_ff, n_in, phi_ff, phi_in;
   logic [15:0] phim_ff, phim_in, kmod_ff, kmod_in, m_ff, m_in;
   logic [31:0] d_ff, d_in, r_ff, r_in, base_ff, base_in, ex_ff, ex_in;
   logic [63:0] mul_ff;
   logic [31:0] mul_a, mul_b;
   logic [31:0] res_plain_ff, res_plain_in, res_priv_ff, res_priv_in;
   logic [1:0]  res_stat_ff, res_stat_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;

   logic [15:0] x_cur;
   logic [16:0] ksum;
   logic [16:0] kdiff;
   logic [15:0] knext;

   div_req_type div_req;
   div_rsp_type div_rsp;

   rsad_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Operand under primality test
   always_comb begin
      case (op_ff)
         OP_P:    x_cur = p_ff;
         OP_Q:    x_cur = q_ff;
         default: x_cur = e_ff;
      endcase
   end

   // Running (1 + m*phi) mod e
   always_comb begin
      ksum  = {1'b0, kmod_ff} + {1'b0, phim_ff};
      kdiff = ksum - {1'b0, e_ff};
      knext = (ksum >= {1'b0, e_ff}) ? kdiff[15:0] : ksum[15:0];
   end

   // Shared multiplier operands
   always_comb begin
      case (state_ff)
         S_NMUL:   begin mul_a = {16'b0, p_ff};          mul_b = {16'b0, q_ff};          end
         S_PHIMUL: begin mul_a = {16'b0, p_ff - 16'd1};  mul_b = {16'b0, q_ff - 16'd1};  end
         S_KMUL:   begin mul_a = {16'b0, m_ff};          mul_b = phi_ff;                 end
         S_RMUL:   begin mul_a = r_ff;                   mul_b = base_ff;                end
         S_SMUL:   begin mul_a = base_ff;                mul_b = base_ff;                end
         default:  begin mul_a = '0;                     mul_b = '0;                     end
      endcase
   end

   // Divider commands
   always_comb begin
      div_req = '0;
      case (state_ff)
         S_PCHK: begin
            div_req.start    = !({1'b0, x_cur} < 17'd2) && !({17'b0, x_cur} > PRIME_LIM)
                               && !(isq_ff > {2'b0, x_cur});
            div_req.len      = DIV_LEN_W'(16);
            div_req.dividend = {x_cur, 48'b0};
            div_req.divisor  = {23'b0, i_ff};
         end
         S_PHIDIV: begin
            div_req.start    = 1'b1;
            div_req.len      = DIV_LEN_W'(32);
            div_req.dividend = {mul_ff[31:0], 32'b0};
            div_req.divisor  = {16'b0, e_ff};
         end
         S_KDIV: begin
            div_req.start    = 1'b1;
            div_req.len      = DIV_LEN_W'(48);
            div_req.dividend = {mul_ff[47:0] + 48'd1, 16'b0};
            div_req.divisor  = {16'b0, e_ff};
         end
         S_CTDIV: begin
            div_req.start    = 1'b1;
            div_req.len      = DIV_LEN_W'(32);
            div_req.dividend = {ct_ff, 32'b0};
            div_req.divisor  = n_ff;
         end
         S_RDIV, S_SDIV: begin
            div_req.start    = 1'b1;
            div_req.len      = DIV_LEN_W'(64);
            div_req.dividend = mul_ff;
            div_req.divisor  = n_ff;
         end
         default: div_req = '0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      e_in         = e_ff;
      ct_in        = ct_ff;
      op_in        = op_ff;
      i_in         = i_ff;
      isq_in       = isq_ff;
      n_in         = n_ff;
      phi_in       = phi_ff;
      phim_in      = phim_ff;
      kmod_in      = kmod_ff;
      m_in         = m_ff;
      d_in         = d_ff;
      r_in         = r_ff;
      base_in      = base_ff;
      ex_in        = ex_ff;
      res_plain_in = res_plain_ff;
      res_priv_in  = res_priv_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               p_in     = req_tdata[15:0];
               q_in     = req_tdata[31:16];
               e_in     = req_tdata[47:32];
               ct_in    = req_tdata[79:48];
               op_in    = OP_P;
               i_in     = 9'd2;
               isq_in   = 18'd4;
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (({1'b0, x_cur} < 17'd2) || ({17'b0, x_cur} > PRIME_LIM)) begin
               res_plain_in = '0;
               res_priv_in  = '0;
               res_stat_in  = STATUS_NOT_PRIME;
               state_in     = S_DONE;
            end else if (isq_ff > {2'b0, x_cur}) begin
               // operand is prime
               i_in   = 9'd2;
               isq_in = 18'd4;
               if (op_ff == OP_E) begin
                  state_in = S_NMUL;
               end else begin
                  op_in = op_ff + 2'd1;
               end
            end else begin
               state_in = S_PWAIT;
            end
         end
         S_PWAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0) begin
                  res_plain_in = '0;
                  res_priv_in  = '0;
                  res_stat_in  = STATUS_NOT_PRIME;
                  state_in     = S_DONE;
               end else begin
                  // (i+1)^2 = i^2 + 2i + 1
                  isq_in   = isq_ff + {8'b0, i_ff, 1'b1};
                  i_in     = i_ff + 9'd1;
                  state_in = S_PCHK;
               end
            end
         end
         S_NMUL:   state_in = S_PHIMUL;
         S_PHIMUL: begin
            n_in     = mul_ff[31:0];
            state_in = S_PHIDIV;
         end
         S_PHIDIV: begin
            phi_in   = mul_ff[31:0];
            state_in = S_PHIWAIT;
         end
         S_PHIWAIT: begin
            if (div_rsp.done) begin
               phim_in  = div_rsp.remainder[15:0];
               kmod_in  = 16'd1;
               m_in     = 16'd1;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (knext == '0) begin
               state_in = S_KMUL;
            end else if (m_ff == e_ff) begin
               res_plain_in = '0;
               res_priv_in  = '0;
               res_stat_in  = STATUS_NO_INVERSE;
               state_in     = S_DONE;
            end else begin
               kmod_in = knext;
               m_in    = m_ff + 16'd1;
            end
         end
         S_KMUL:  state_in = S_KDIV;
         S_KDIV:  state_in = S_KWAIT;
         S_KWAIT: begin
            if (div_rsp.done) begin
               d_in     = div_rsp.quotient[31:0];
               state_in = S_CTDIV;
            end
         end
         S_CTDIV: state_in = S_CTWAIT;
         S_CTWAIT: begin
            if (div_rsp.done) begin
               base_in  = div_rsp.remainder;
               r_in     = 32'd1;
               ex_in    = d_ff;
               state_in = S_EXP;
            end
         end
         S_EXP: begin
            if (ex_ff == '0) begin
               res_plain_in = r_ff;
               res_priv_in  = d_ff;
               res_stat_in  = STATUS_OK;
               state_in     = S_DONE;
            end else if (ex_ff[0]) begin
               state_in = S_RMUL;
            end else begin
               state_in = S_SMUL;
            end
         end
         S_RMUL: state_in = S_RDIV;
         S_RDIV: state_in = S_RWAIT;
         S_RWAIT: begin
            if (div_rsp.done) begin
               r_in     = div_rsp.remainder;
               state_in = S_SMUL;
            end
         end
         S_SMUL: state_in = S_SDIV;
         S_SDIV: state_in = S_SWAIT;
         S_SWAIT: begin
            if (div_rsp.done) begin
               base_in  = div_rsp.remainder;
               ex_in    = {1'b0, ex_ff[31:1]};
               state_in = S_EXP;
            end
         end
         S_DONE: begin
            // wait for the output register to free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, res_stat_ff, res_priv_ff, res_plain_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff         <= p_in;
      q_ff         <= q_in;
      e_ff         <= e_in;
      ct_ff        <= ct_in;
      op_ff        <= op_in;
      i_ff         <= i_in;
      isq_ff       <= isq_in;
      n_ff         <= n_in;
      phi_ff       <= phi_in;
      phim_ff      <= phim_in;
      kmod_ff      <= kmod_in;
      m_ff         <= m_in;
      d_ff         <= d_in;
      r_ff         <= r_in;
      base_ff      <= base_in;
      ex_ff        <= ex_in;
      mul_ff       <= mul_a * mul_b;
      res_plain_ff <= res_plain_in;
      res_priv_ff  <= res_priv_in;
      res_stat_ff  <= res_stat_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // Divider is never restarted mid-operation
   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // Error results carry zero payload
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[65:64] != STATUS_OK)
      |-> (rsp_tdata[63:0] == 64'd0))
      else $error("error result with nonzero payload");

   // A pending result is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pending result lost");

   // Accepted item leaves idle at once
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("still idle after accepting an item");
`endif

endmodule

// ===== test/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for rsa_decrypt_from_primes: drives prime/exponent/
// ciphertext transactions, predicts plaintext, d and status, and compares.
// ============================================================================
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rsad_pkg::*;

   typedef struct {
      logic [31:0] plain;
      logic [31:0] dexp;
      logic [1:0]  status;
   } rsa_answer_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts each decryption and checks results in order
   // -------------------------------------------------------------------------
   class rsa_scoreboard;
      rsa_answer_type pending[$];
      int errors;
      int checked;
      int n_ok, n_bad, n_noinv;

      function bit prime_ok(longint unsigned x);
         longint unsigned i;
         if (x < 2) return 0;
         if (x > ((64'd1 << PRIME_BITS) - 1)) return 0;
         for (i = 2; i * i <= x; i++)
            if (x % i == 0) return 0;
         return 1;
      endfunction

      function longint unsigned mod_power(longint unsigned b, longint unsigned ex,
                                          longint unsigned md);
         longint unsigned r;
         r = 1 % md;
         b = b % md;
         while (ex != 0) begin
            if (ex[0]) r = (r * b) % md;
            b = (b * b) % md;
            ex = ex >> 1;
         end
         return r;
      endfunction

      // note an accepted input and queue its expected result
      function void note_request(logic [15:0] p, logic [15:0] q, logic [15:0] e,
                                 logic [31:0] ct);
         rsa_answer_type a;
         longint unsigned n, phi, k, d;
         bit found;
         a.plain = 0; a.dexp = 0; a.status = STATUS_OK;
         found = 0; d = 0;
         if (!prime_ok(p) || !prime_ok(q) || !prime_ok(e)) begin
            a.status = STATUS_NOT_PRIME;
            n_bad++;
         end else begin
            n = p * q;
            phi = (p - 1) * (q - 1);
            k = 1;
            for (longint unsigned m = 1; m <= e && !found; m++) begin
               k += phi;
               if (k % e == 0) begin
                  d = k / e;
                  found = 1;
               end
            end
            if (!found) begin
               a.status = STATUS_NO_INVERSE;
               n_noinv++;
            end else begin
               a.plain = 32'(mod_power(ct % n, d, n));
               a.dexp = 32'(d);
               n_ok++;
            end
         end
         pending.push_back(a);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0h expected %0h", what, got, want);
         errors++;
      endtask

      // check one accepted result against the oldest expectation
      task check_result(logic [71:0] data);
         rsa_answer_type a;
         if (pending.size() == 0) begin
            report("unexpected result", data[31:0], 0);
            return;
         end
         a = pending.pop_front();
         checked++;
         if (data[31:0] !== a.plain) report("plain_value", data[31:0], a.plain);
         if (data[63:32] !== a.dexp) report("priv_exponent", data[63:32], a.dexp);
         if (data[65:64] !== a.status) report("status", data[65:64], a.status);
         if (data[71:66] !== 6'd0) report("padding", data[71:66], 0);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;

   rsa_scoreboard board;
   bit hold_off;
   bit stim_done;

   rsa_decrypt_from_primes DUT (.*);

   // clock generation
   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // small primes keep the run short; a few large ones stress latency
   localparam int NPR = 16;
   int unsigned prime_pool[NPR] = '{2, 3, 5, 7, 11, 13, 17, 101, 251, 257,
                                    1009, 4093, 65521, 65519, 3, 65537};

   function logic [15:0] pick_prime();
      int unsigned v;
      v = prime_pool[$urandom_range(0, NPR - 3)];
      if ($urandom_range(0, 9) == 0) v = prime_pool[$urandom_range(12, 13)];
      return v[15:0];
   endfunction

   // send one transaction, hold it until accepted, and note it in the scoreboard
   task automatic send_item(logic [15:0] p, logic [15:0] q, logic [15:0] e,
                            logic [31:0] ct);
      req_tvalid <= 1'b1;
      req_tdata  <= {ct, e, q, p};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(p, q, e, ct);
   endtask

   task automatic idle_gap();
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   endtask

   // stimulus
   initial begin
      logic [15:0] p, q, e;
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      stim_done = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, one, composites, wide-ish, no inverse, big ct
      send_item(0, 5, 3, 32'd7);
      send_item(5, 1, 3, 32'd7);
      send_item(7, 11, 0, 32'd7);
      send_item(9, 11, 3, 32'd7);
      send_item(7, 15, 3, 32'd7);
      send_item(7, 11, 1, 32'd7);
      send_item(65535, 3, 5, 32'd1);
      send_item(61, 53, 17, 32'd65);
      send_item(61, 53, 17, 32'hFFFF_FFFF);
      send_item(7, 11, 3, 32'd0);
      send_item(7, 11, 5, 32'd5);
      send_item(2, 2, 2, 32'd3);
      send_item(2, 3, 3, 32'd5);
      send_item(3, 5, 2, 32'd14);
      send_item(65521, 65519, 65521, 32'hFFFF_FFFF);
      send_item(65521, 3, 7, 32'h8000_0000);
      send_item(13, 17, 65521, 32'h1234_5678);
      send_item(101, 251, 257, 32'hAAAA_5555);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0);

      // random: mostly valid primes, some raw noise
      for (int i = 0; i < 100; i++) begin
         idle_gap();
         if ($urandom_range(0, 4) == 0) begin
            p = 16'($urandom);
            q = 16'($urandom);
            e = 16'($urandom_range(0, 300));
         end else begin
            p = pick_prime(); q = pick_prime(); e = pick_prime();
            if (e > 300 && $urandom_range(0, 3) != 0) e = 16'd17;
         end
         send_item(p, q, e, $urandom);
      end
      req_tvalid <= 1'b0;
      stim_done = 1;
   end

   // receiver: random stall pattern, plus one long hold-off
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) rsp_tready <= 1'b0;
         else rsp_tready <= ($urandom_range(0, 7) < 5) || ((board.checked / 16) % 2 == 1);
      end
   end

   initial begin
      @(negedge reset);
      while (board.checked < 30) @(posedge clock);
      hold_off = 1;
      repeat (60000) @(posedge clock);
      hold_off = 0;
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   // end of run
   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("tb: %0d results checked (%0d ok, %0d rejected, %0d no inverse)",
               board.checked, board.n_ok, board.n_bad, board.n_noinv);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // timeout
   initial begin
      #(64'd1_000_000_000);
      $display("tb: timeout");
      $display("tb: errors");
      $finish;
   end
endmodule
